FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion name failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion name failed");

`endif

FILE: rtl/core/s256_pkg.sv
// types, constants and round functions of the sha-256 stream hasher
// no dependencies
package s256_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        extra;
    logic [63:0] bit_len;
  } q_entry_t;

  localparam logic [31:0] PadMarker = 32'h8000_0000;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: rtl/core/s256_queue.sv
// short register queue between the word front end and the hash back end
// depends on s256_pkg
module s256_queue import s256_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t entry_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/s256_front.sv
// input front end: byte counting, last word masking and marker insertion
// depends on s256_pkg
module s256_front import s256_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  logic [60:0] bytes_q, bytes_d, bytes_sum;
  logic [2:0]  vb_sat;
  logic [4:0]  shamt;
  logic        accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    if (!in_item_i.last_word || (in_item_i.valid_bytes > 3'd4)) begin
      vb_sat = 3'd4;
    end else begin
      vb_sat = in_item_i.valid_bytes;
    end
    shamt     = {vb_sat[1:0], 3'b000};
    bytes_sum = bytes_q + 61'(vb_sat);

    q_entry_o.last    = in_item_i.last_word;
    q_entry_o.extra   = in_item_i.last_word && (vb_sat == 3'd4);
    q_entry_o.bit_len = {bytes_sum, 3'b000};
    if (in_item_i.last_word && (vb_sat != 3'd4)) begin
      q_entry_o.word = (in_item_i.data_word & ~(32'hffff_ffff >> shamt))
                     | (PadMarker >> shamt);
    end else begin
      q_entry_o.word = in_item_i.data_word;
    end

    bytes_d = bytes_q;
    if (accept) begin
      bytes_d = in_item_i.last_word ? '0 : bytes_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
    end else begin
      bytes_q <= bytes_d;
    end
  end

endmodule

FILE: rtl/core/s256_back.sv
// hash back end: block window, padding sequencer, one-round-per-cycle
// compression and digest output; depends on s256_pkg
module s256_back import s256_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  q_entry_t  q_entry_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_PAD80 = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_LENHI = 3'd3;
  localparam logic [2:0] ST_LENLO = 3'd4;
  localparam logic [2:0] ST_COMP  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]  state_q, state_d, ret_q, ret_d;
  logic [3:0]  fill_q, fill_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] len_q, len_d;
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] work_q [8];
  logic [31:0] work_d [8];
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];

  logic        push_en;
  logic [31:0] push_word;
  logic [2:0]  push_next;
  logic [31:0] t1, t2, w_new;

  assign out_valid_o            = (state_q == ST_OUT);
  assign out_item_o.digest_word = chain_q[idx_q];
  assign out_item_o.word_index  = idx_q;
  assign out_item_o.last_result = (idx_q == 3'd7);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    fill_d    = fill_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    len_d     = len_q;
    win_d     = win_q;
    work_d    = work_q;
    chain_d   = chain_q;
    q_pop_o   = 1'b0;
    push_en   = 1'b0;
    push_word = '0;
    push_next = state_q;

    t1 = work_q[7] + big_sigma1(work_q[4])
       + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
       + RoundK[rnd_q[5:0]] + win_q[0];
    t2 = big_sigma0(work_q[0])
       + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
    w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

    case (state_q)
      ST_FILL: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          push_en   = 1'b1;
          push_word = q_entry_i.word;
          if (!q_entry_i.last) begin
            push_next = ST_FILL;
          end else begin
            len_d     = q_entry_i.bit_len;
            push_next = q_entry_i.extra ? ST_PAD80 : ST_ZERO;
          end
        end
      end
      ST_PAD80: begin
        push_en   = 1'b1;
        push_word = PadMarker;
        push_next = ST_ZERO;
      end
      ST_ZERO: begin
        if (fill_q != 4'd14) begin
          push_en   = 1'b1;
          push_next = ST_ZERO;
        end else begin
          state_d = ST_LENHI;
        end
      end
      ST_LENHI: begin
        push_en   = 1'b1;
        push_word = len_q[63:32];
        push_next = ST_LENLO;
      end
      ST_LENLO: begin
        push_en   = 1'b1;
        push_word = len_q[31:0];
        push_next = ST_OUT;
      end
      ST_COMP: begin
        if (!rnd_q[6]) begin
          for (int i = 7; i > 0; i--) begin
            work_d[i] = work_q[i-1];
          end
          work_d[4] = work_q[3] + t1;
          work_d[0] = t1 + t2;
          for (int i = 0; i < 15; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[15] = w_new;
          rnd_d     = rnd_q + 7'd1;
        end else begin
          for (int i = 0; i < 8; i++) begin
            chain_d[i] = chain_q[i] + work_q[i];
          end
          state_d = ret_q;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            chain_d = InitHash;
            state_d = ST_FILL;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase

    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = push_word;
      fill_d    = fill_q + 4'd1;
      if (fill_q == 4'd15) begin
        state_d = ST_COMP;
        ret_d   = push_next;
        rnd_d   = '0;
        work_d  = chain_q;
      end else begin
        state_d = push_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    work_q <= work_d;
    len_q  <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      ret_q   <= ST_FILL;
      fill_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      chain_q <= InitHash;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      chain_q <= chain_d;
    end
  end

endmodule

FILE: rtl/core/sha256_stream_hasher.sv
// sha-256 stream hasher top: front end, word queue and hash back end
// each word popped from the queue shifts into the 16-word window; a full block
// then takes 64 rounds plus a fold into the chaining hash, and words wait in the
// queue while the back end compresses
// a last word gives its digest once the padded block is compressed, after a second
// block when the length spills over; reset loads the initial hash at once
`include "assert_macros.svh"

module sha256_stream_hasher import s256_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_wr_entry, q_rd_entry;
  logic     digest_done;

  s256_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr_entry)
  );

  s256_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  s256_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign digest_done = out_valid_o && !out_stall_i && out_item_o.last_result;

  `ASSERT_IMPLY(a_pop_needs_word, clk_i, rst_ni, q_pop, !q_empty)
  `ASSERT_IMPLY(a_no_pop_while_output, clk_i, rst_ni, out_valid_o, !q_pop)
  `ASSERT_NEXT(a_digest_ends, clk_i, rst_ni, digest_done, !out_valid_o)

endmodule

FILE: bench/sha256_stream_hasher_tb.sv
// testbench of sha256_stream_hasher: directed and random messages hashed against a
// scoreboard that folds every 16-word block itself and queues the eight digest words
// depends on s256_pkg for the word types of both channels
module sha256_stream_hasher_tb import s256_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_WORDS = 14;

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [3:0]  fill;
    logic [60:0] byte_count;
    out_item_t   pending_digest [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
      for (int i = 0; i < 16; i++) blk[i] = '0;
      fill = '0;
      byte_count = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void add_word(logic [31:0] w);
      blk[fill] = w;
      fill = fill + 4'd1;
      if (fill == 4'd0) fold_block();
    endfunction

    function void note_word(in_item_t it);
      int unsigned n;
      logic [31:0] keep;
      logic [63:0] bits;
      out_item_t   dw;
      if (!it.last_word) begin
        byte_count = byte_count + 61'd4;
        add_word(it.data_word);
        return;
      end
      n = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
      byte_count = byte_count + 61'(n);
      if (n < 4) begin
        keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
        add_word((it.data_word & keep) | (32'h80 << (24 - 8 * n)));
      end else begin
        add_word(it.data_word);
        add_word(32'h8000_0000);
      end
      // no room left for the length: pad out a whole extra block
      if (fill > 4'd14) begin
        while (fill != 4'd0) add_word('0);
      end
      while (fill < 4'd14) add_word('0);
      bits = {byte_count, 3'b000};
      add_word(bits[63:32]);
      add_word(bits[31:0]);
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = chain[i];
        dw.word_index = 3'(i);
        dw.last_result = (i == 7);
        pending_digest.push_back(dw);
      end
      restart();
    endfunction

    function void check_digest(out_item_t got);
      out_item_t want;
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                 got.digest_word, got.word_index, got.last_result);
        errors++;
        return;
      end
      want = pending_digest.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", $time,
                 want.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $display("%0t: word_index expected %0d actual %0d", $time,
                 want.word_index, got.word_index);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $display("%0t: last_result expected %0b actual %0b", $time,
                 want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  digest_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned phase_words;

  sha256_stream_hasher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic send_word(input logic [31:0] data, input logic [2:0] vb,
                           input logic last);
    in_item_t it;
    it.data_word = data;
    it.valid_bytes = vb;
    it.last_word = last;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    sb.note_word(it);
    phase_words++;
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_message();
    int unsigned len;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: len = $urandom_range(8);
      6, 7: len = $urandom_range(17, 12);
      8: len = $urandom_range(33, 28);
      default: len = 0;
    endcase
    repeat (len) send_word(pick_data(), 3'($urandom_range(7)), 1'b0);
    send_word(pick_data(), 3'($urandom_range(7)), 1'b1);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_digest(out_item);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("sha256_stream_hasher_tb failed");
    $finish;
  end

  initial begin
    in_valid = 1'b0;
    in_item = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty message, then every valid_bytes value from 1 to 7 on a one-word message
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    for (int n = 1; n <= 7; n++) send_word(32'hffff_ffff, 3'(n), 1'b1);
    // length spills into a second final block; byte counts ignored on body words
    for (int i = 0; i < 14; i++)
      send_word((i % 2) ? 32'hffff_ffff : 32'h0, 3'(i), 1'b0);
    send_word(32'h8badf00d, 3'd1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase == 0) hold_requests++;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) send_message();
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending_digest.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_digest.size() == 0) begin
      $display("sha256_stream_hasher_tb passed");
    end else begin
      $display("sha256_stream_hasher_tb failed");
    end
    $finish;
  end

endmodule

FILE: sha256_stream_hasher.f
+incdir+rtl/core
rtl/core/s256_pkg.sv
rtl/core/s256_queue.sv
rtl/core/s256_front.sv
rtl/core/s256_back.sv
rtl/core/sha256_stream_hasher.sv
bench/sha256_stream_hasher_tb.sv
